// ----- design/bscd_pkg.sv -----
// ----------------------------------------------------------------------------
// bscd_pkg
// Shared types and constants of the bright spot centroid hit detector.
// ----------------------------------------------------------------------------
package bscd_pkg;

    // Default raster limits.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register widths and reset values.
    localparam int FW_W    = 11;
    localparam int TH_W    = 8;
    localparam int TGT_W   = 10;
    localparam int CFG_W   = 11;
    localparam int ADDR_W  = 3;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST   = 11'd1024;
    localparam logic [TH_W-1:0]  THRESHOLD_RST     = 8'd230;
    localparam logic [TGT_W-1:0] TARGET_X_RST      = 10'd512;
    localparam logic [TGT_W-1:0] TARGET_Y_RST      = 10'd384;
    localparam logic [TGT_W-1:0] TARGET_RADIUS_RST = 10'd40;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;
    localparam int SPOT_W      = 10;
    localparam int SCNT_W      = 21;
    localparam int RR_W        = 2 * TGT_W;

    // Bit positions in the result tdata.
    localparam int OB_SPOT_X   = 24;
    localparam int OB_SPOT_Y   = 34;
    localparam int OB_COUNT    = 44;
    localparam int OB_NEW_SHOT = 65;
    localparam int OB_HIT      = 66;
    localparam int OUT_USED_W  = 67;

    typedef enum logic [ADDR_W-1:0] {
        CFG_FRAME_WIDTH     = 3'd0,
        CFG_VALUE_THRESHOLD = 3'd1,
        CFG_TARGET_X        = 3'd2,
        CFG_TARGET_Y        = 3'd3,
        CFG_TARGET_RADIUS   = 3'd4
    } cfg_idx_t;

    // Result kinds carried on tuser.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_DIV,
        ST_SQUARE,
        ST_SUMMARY
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;        // pixel beat taken this cycle
        logic div_step;      // one quotient bit
        logic square_en;     // register distance squares
        logic load_summary;  // place the frame summary in the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;      // output register can take a beat this cycle
        logic div_last;      // final quotient bit in progress
    } status_t;

endpackage

// ----- design/bscd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bscd_ctrl
// Sequencer: pixel pass, centroid division, distance square, summary.
// ----------------------------------------------------------------------------
module bscd_ctrl
    import bscd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    output cmd_t    cmd,
    input  status_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PIXEL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        s_tready         = 1'b0;
        unique case (state_reg)
            ST_PIXEL: begin
                s_tready   = sts.out_free;
                cmd.accept = s_tvalid && sts.out_free;
                if (cmd.accept && s_tlast) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square_en = 1'b1;
                state_next    = ST_SUMMARY;
            end
            ST_SUMMARY: begin
                cmd.load_summary = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_PIXEL;
                end
            end
            default: begin
                state_next = ST_PIXEL;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A frame end always starts the division.
    a_frame_end_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_tlast) |=> (state_reg == ST_DIV))
        else $error("frame end did not start division");

    // The square stage follows only the last quotient bit.
    a_square_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQUARE) |-> ($past(state_reg) == ST_DIV && $past(sts.div_last)))
        else $error("square stage entered early");
`endif

endmodule

// ----- design/bscd_datapath.sv -----
// ----------------------------------------------------------------------------
// bscd_datapath
// Config registers, position counters, sums, divider, hit test, output register.
// ----------------------------------------------------------------------------
module bscd_datapath
    import bscd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast,
    input  cmd_t                   cmd,
    output status_t                sts
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int MAX_PIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNT_W   = $clog2(MAX_PIX + 1);
    localparam int DQ      = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DS_W    = DQ + CNT_W;
    localparam int DCW     = (DQ > 1) ? $clog2(DQ) : 1;
    localparam int EW      = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int DXW     = ((DQ > TGT_W) ? DQ : TGT_W) + 1;
    localparam int SQ_W    = 2 * DXW;
    localparam int PAD_W   = OUT_TDATA_W - OUT_USED_W;

    // Configuration
    logic [FW_W-1:0]  frame_width_reg;
    logic [TH_W-1:0]  threshold_reg;
    logic [TGT_W-1:0] target_x_reg;
    logic [TGT_W-1:0] target_y_reg;
    logic [TGT_W-1:0] target_radius_reg;

    // Frame accumulation
    logic [COL_W-1:0] column_reg;
    logic [ROW_W-1:0] row_reg;
    logic [DS_W-1:0]  sum_x_reg;
    logic [DS_W-1:0]  sum_y_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             shot_reg;

    // Divider and hit test
    logic [DS_W-1:0]  rem_x_reg;
    logic [DS_W-1:0]  rem_y_reg;
    logic [DS_W-1:0]  dvs_reg;
    logic [DQ-1:0]    q_x_reg;
    logic [DQ-1:0]    q_y_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [CNT_W-1:0] cnt_hold_reg;
    logic [SQ_W-1:0]  sq_x_reg;
    logic [SQ_W-1:0]  sq_y_reg;
    logic [RR_W-1:0]  rr_reg;

    // Output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;

    // Pixel path
    logic [7:0]       px_blue;
    logic [7:0]       px_green;
    logic [7:0]       px_red;
    logic             bright;
    logic             add_en;
    logic [DS_W-1:0]  sum_x_next;
    logic [DS_W-1:0]  sum_y_next;
    logic [CNT_W-1:0] cnt_next;
    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    eff_width;
    logic [EW-1:0]    col_inc;
    logic             col_wrap;
    logic             row_wrap;

    assign px_blue  = s_tdata[7:0];
    assign px_green = s_tdata[15:8];
    assign px_red   = s_tdata[23:16];
    assign bright   = (px_blue >= threshold_reg) || (px_green >= threshold_reg)
                      || (px_red >= threshold_reg);
    assign add_en   = bright && (cnt_reg < CNT_W'(MAX_PIX));

    assign sum_x_next = add_en ? sum_x_reg + DS_W'(column_reg) : sum_x_reg;
    assign sum_y_next = add_en ? sum_y_reg + DS_W'(row_reg) : sum_y_reg;
    assign cnt_next   = add_en ? cnt_reg + CNT_W'(1) : cnt_reg;

    // Zero width acts as one, oversize clamps to the raster limit.
    assign fw_ext = EW'(frame_width_reg);
    always_comb begin
        eff_width = fw_ext;
        if (fw_ext == '0) begin
            eff_width = EW'(1);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end
    end
    assign col_inc  = EW'(column_reg) + EW'(1);
    assign col_wrap = col_inc >= eff_width;
    assign row_wrap = row_reg == ROW_W'(MAX_HEIGHT - 1);

    // Divider step: restoring, one quotient bit per cycle on both axes.
    logic x_ge;
    logic y_ge;
    assign x_ge = rem_x_reg >= dvs_reg;
    assign y_ge = rem_y_reg >= dvs_reg;

    // Hit test
    logic [DXW-1:0]        qx_ext;
    logic [DXW-1:0]        qy_ext;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic signed [SQ_W-1:0] dx_sq;
    logic signed [SQ_W-1:0] dy_sq;
    logic [RR_W-1:0]       rr_next;
    logic [SQ_W:0]         dist_sum;
    logic                  have_spot;
    logic                  new_shot;
    logic                  hit;
    logic [SPOT_W-1:0]     spot_x;
    logic [SPOT_W-1:0]     spot_y;
    logic [CNT_W+SCNT_W-1:0] cnt_ext;

    assign qx_ext   = DXW'(q_x_reg);
    assign qy_ext   = DXW'(q_y_reg);
    assign dx       = $signed(qx_ext) - $signed(DXW'(target_x_reg));
    assign dy       = $signed(qy_ext) - $signed(DXW'(target_y_reg));
    assign dx_sq    = SQ_W'(dx) * SQ_W'(dx);
    assign dy_sq    = SQ_W'(dy) * SQ_W'(dy);
    assign rr_next  = RR_W'(target_radius_reg) * RR_W'(target_radius_reg);
    assign dist_sum = (SQ_W+1)'(sq_x_reg) + (SQ_W+1)'(sq_y_reg);

    assign have_spot = cnt_hold_reg != '0;
    assign new_shot  = have_spot && !shot_reg;
    assign hit       = new_shot && (dist_sum < (SQ_W+1)'(rr_reg));
    assign spot_x    = have_spot ? qx_ext[SPOT_W-1:0] : '0;
    assign spot_y    = have_spot ? qy_ext[SPOT_W-1:0] : '0;
    assign cnt_ext   = (CNT_W+SCNT_W)'(cnt_hold_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            threshold_reg     <= THRESHOLD_RST;
            target_x_reg      <= TARGET_X_RST;
            target_y_reg      <= TARGET_Y_RST;
            target_radius_reg <= TARGET_RADIUS_RST;
            column_reg        <= '0;
            row_reg           <= '0;
            sum_x_reg         <= '0;
            sum_y_reg         <= '0;
            cnt_reg           <= '0;
            shot_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_FRAME_WIDTH:     frame_width_reg   <= cfg_wdata;
                    CFG_VALUE_THRESHOLD: threshold_reg     <= cfg_wdata[TH_W-1:0];
                    CFG_TARGET_X:        target_x_reg      <= cfg_wdata[TGT_W-1:0];
                    CFG_TARGET_Y:        target_y_reg      <= cfg_wdata[TGT_W-1:0];
                    CFG_TARGET_RADIUS:   target_radius_reg <= cfg_wdata[TGT_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.accept) begin
                if (s_tlast) begin
                    column_reg <= '0;
                    row_reg    <= '0;
                    sum_x_reg  <= '0;
                    sum_y_reg  <= '0;
                    cnt_reg    <= '0;
                end else begin
                    sum_x_reg <= sum_x_next;
                    sum_y_reg <= sum_y_next;
                    cnt_reg   <= cnt_next;
                    if (col_wrap) begin
                        column_reg <= '0;
                        row_reg    <= row_wrap ? '0 : row_reg + ROW_W'(1);
                    end else begin
                        column_reg <= COL_W'(col_inc);
                    end
                end
            end

            if (cmd.load_summary) begin
                shot_reg <= have_spot;
            end

            if (cmd.accept || cmd.load_summary) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_tlast) begin
            rem_x_reg    <= sum_x_next;
            rem_y_reg    <= sum_y_next;
            dvs_reg      <= DS_W'(cnt_next) << (DQ - 1);
            cnt_hold_reg <= cnt_next;
            div_cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            if (x_ge) begin
                rem_x_reg <= rem_x_reg - dvs_reg;
            end
            if (y_ge) begin
                rem_y_reg <= rem_y_reg - dvs_reg;
            end
            q_x_reg     <= DQ'({q_x_reg, x_ge});
            q_y_reg     <= DQ'({q_y_reg, y_ge});
            dvs_reg     <= dvs_reg >> 1;
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end

        if (cmd.square_en) begin
            sq_x_reg <= $unsigned(dx_sq);
            sq_y_reg <= $unsigned(dy_sq);
            rr_reg   <= rr_next;
        end

        if (cmd.accept) begin
            m_tdata_reg <= {{(OUT_TDATA_W-IN_TDATA_W){1'b0}},
                            bright ? px_red   : 8'd0,
                            bright ? px_green : 8'd0,
                            bright ? px_blue  : 8'd0};
            m_tuser_reg <= KIND_PIXEL;
            m_tlast_reg <= !s_tlast;
        end else if (cmd.load_summary) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, hit, new_shot, cnt_ext[SCNT_W-1:0],
                            spot_y, spot_x, {IN_TDATA_W{1'b0}}};
            m_tuser_reg <= KIND_SUMMARY;
            m_tlast_reg <= 1'b1;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.div_last = div_cnt_reg == DCW'(DQ - 1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // A summary beat always closes the results of its pixel.
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tlast)
        else $error("summary beat without tlast");

    // A hit is only reported together with a new shot.
    a_hit_needs_shot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OB_HIT]) |-> m_tdata[OB_NEW_SHOT])
        else $error("hit reported without new shot");
`endif

endmodule

// ----- design/bright_spot_centroid_hit_detector.sv -----
// ----------------------------------------------------------------------------
// bright_spot_centroid_hit_detector
// Bright spot mask, per-frame centroid and target hit decision on a BGR stream.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one pixel per beat on the s_ channel, tlast on the last pixel of a
//   frame. Every pixel beat yields one masked pixel beat on the m_ channel
//   (tuser = 0): the pixel as is when any channel reaches value_threshold,
//   black otherwise. The frame-end pixel is followed by a summary beat
//   (tuser = 1) with the truncated centroid, bright pixel count, new-shot and
//   hit flags; m_tlast marks the last beat caused by each input beat.
//   A pixel beat appears in the cycle after it is taken. Throughput is
//   one pixel per cycle within a frame while the output register is free.
//   After the frame-end pixel the input holds off while the restoring divider
//   produces one centroid bit per cycle on both axes (Q-bit quotients, Q =
//   clog2 of the larger raster limit, 10 by default), then the distance
//   squares are registered, then the summary enters the output register.
//   The single output register stalls the input while a beat waits and
//   m_tready is low. Reset (aresetn low, synchronous) restores register
//   defaults, clears position, sums and count, and returns to waiting for a
//   shot. Write configuration only while idle.
// ----------------------------------------------------------------------------
module bright_spot_centroid_hit_detector
    import bscd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write port
    input  logic                   cfg_we,
    input  logic [ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,

    // Pixel input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic                   s_tlast,   // frame_end

    // Results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_blue[7:0], out_green[15:8],
                                              // out_red[23:16], spot_x[33:24],
                                              // spot_y[43:34], spot_count[64:44],
                                              // new_shot[65], hit[66], zero[71:67]
    output logic                   m_tuser,   // kind
    output logic                   m_tlast    // last
);

    cmd_t    cmd;
    status_t sts;

    // Sequence the pixel pass and the end-of-frame work.
    bscd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Hold configuration, accumulate, divide, test and drive the result beat.
    bscd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
